// ===== hdl/tti_pkg.sv =====
package tti_pkg;

    // Default coordinate width (Q11.10) and packed point field width
    localparam int COORD_BITS_DEF = 21;
    localparam int FIELD_W = 63;

    // Segment-versus-triangle engines used in triangle mode
    localparam int SEG_TESTS = 6;

    // Engine stages outside the divider
    localparam int SEG_FIXED_STAGES = 12;

    // One quotient bit per divider stage
    function automatic int div_stages(input int coord_bits);
        return coord_bits + 1;
    endfunction

    function automatic int seg_latency(input int coord_bits);
        return div_stages(coord_bits) + SEG_FIXED_STAGES;
    endfunction

endpackage

// ===== hdl/tti_seg.sv =====
module tti_seg
    import tti_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic                    clk,
    input  logic [3*COORD_BITS-1:0] tri_a,
    input  logic [3*COORD_BITS-1:0] tri_b,
    input  logic [3*COORD_BITS-1:0] tri_c,
    input  logic [3*COORD_BITS-1:0] seg_a,
    input  logic [3*COORD_BITS-1:0] seg_b,
    output logic                    hit,
    output logic [3*COORD_BITS-1:0] point
);

    localparam int C   = COORD_BITS;
    localparam int D   = div_stages(COORD_BITS);   // difference width, quotient bits
    localparam int NW  = 2 * D + 1;                // cross product component
    localparam int PW  = NW + D;                   // n times d product
    localparam int DW  = PW + 2;                   // den / num
    localparam int AW  = DW;                       // magnitudes
    localparam int H   = (AW + 1) / 2;             // split of anum
    localparam int RW  = AW + D + 2;               // divider remainder
    localparam int L   = (NW + 1) / 2;             // split of c2
    localparam int PLW = NW + L + 1;
    localparam int PHW = 2 * NW - L;
    localparam int EW  = 2 * NW + 3;               // edge dot product
    localparam int SD_DEPTH = D + 7;

    typedef logic [2:0][C-1:0]  vec_t;
    typedef logic [2:0][D-1:0]  dvec_t;
    typedef logic [2:0][NW-1:0] nvec_t;

    typedef struct packed {
        vec_t  t0;
        vec_t  t1;
        vec_t  t2;
        vec_t  a;
        dvec_t d;
    } side_t;

    function automatic dvec_t vdiff(input vec_t x, input vec_t y);
        dvec_t r;
        logic signed [D-1:0] xs;
        logic signed [D-1:0] ys;
        for (int k = 0; k < 3; k++) begin
            xs = $signed(x[k]);
            ys = $signed(y[k]);
            r[k] = xs - ys;
        end
        return r;
    endfunction

    function automatic nvec_t vcross(input dvec_t x, input dvec_t y);
        nvec_t r;
        logic signed [NW-1:0] p;
        logic signed [NW-1:0] q;
        p = $signed(x[1]) * $signed(y[2]);
        q = $signed(x[2]) * $signed(y[1]);
        r[0] = p - q;
        p = $signed(x[2]) * $signed(y[0]);
        q = $signed(x[0]) * $signed(y[2]);
        r[1] = p - q;
        p = $signed(x[0]) * $signed(y[1]);
        q = $signed(x[1]) * $signed(y[0]);
        r[2] = p - q;
        return r;
    endfunction

    // side data delay line, index j holds data of stage j+1
    side_t side_next;
    side_t side_reg [SD_DEPTH];

    // stage 1: edge and segment differences
    dvec_t e1_next, e2_next, w_next;
    dvec_t e1_reg, e2_reg, w_reg;

    always_comb
    begin
        e1_next = vdiff(tri_b, tri_a);
        e2_next = vdiff(tri_c, tri_a);
        w_next  = vdiff(tri_a, seg_a);
        side_next.t0 = tri_a;
        side_next.t1 = tri_b;
        side_next.t2 = tri_c;
        side_next.a  = seg_a;
        side_next.d  = vdiff(seg_b, seg_a);
    end

    // stage 2: plane normal
    nvec_t n_next, n_reg;
    dvec_t w2_reg;

    assign n_next = vcross(e1_reg, e2_reg);

    // stage 3: products of the two dot products
    logic [2:0][PW-1:0] pden_next, pnum_next, pden_reg, pnum_reg;

    always_comb
    begin
        logic signed [PW-1:0] pd;
        logic signed [PW-1:0] pn;
        for (int k = 0; k < 3; k++) begin
            pd = $signed(n_reg[k]) * $signed(side_reg[1].d[k]);
            pn = $signed(n_reg[k]) * $signed(w2_reg[k]);
            pden_next[k] = pd;
            pnum_next[k] = pn;
        end
    end

    // stage 4: den and num
    logic [DW-1:0] den_next, num_next, den_reg, num_reg;

    always_comb
    begin
        logic signed [DW-1:0] sd;
        logic signed [DW-1:0] sn;
        sd = $signed(pden_reg[0]);
        sn = $signed(pnum_reg[0]);
        for (int k = 1; k < 3; k++) begin
            sd = sd + $signed(pden_reg[k]);
            sn = sn + $signed(pnum_reg[k]);
        end
        den_next = sd;
        num_next = sn;
    end

    // stage 5: sign checks, t in [0,1], magnitudes
    logic [AW-1:0] anum_next, aden_next, anum_reg, aden_reg;
    logic          ok5_next, ok5_reg;

    always_comb
    begin
        anum_next = num_reg[DW-1] ? (AW'(0) - num_reg) : num_reg;
        aden_next = den_reg[DW-1] ? (AW'(0) - den_reg) : den_reg;
        ok5_next  = (den_reg != '0)
                 && ((num_reg == '0) || (num_reg[DW-1] == den_reg[DW-1]))
                 && (anum_next <= aden_next);
    end

    // stage 6: anum * |d|, as two partial products per axis
    logic [2:0][H+D-1:0]    pl_next, pl_reg;
    logic [2:0][AW-H+D-1:0] ph_next, ph_reg;
    logic [AW-1:0]          aden6_reg;
    logic                   ok6_reg;

    always_comb
    begin
        logic [D-1:0] ad;
        for (int k = 0; k < 3; k++) begin
            ad = side_reg[4].d[k][D-1] ? (D'(0) - side_reg[4].d[k]) : side_reg[4].d[k];
            pl_next[k] = anum_reg[H-1:0] * ad;
            ph_next[k] = anum_reg[AW-1:H] * ad;
        end
    end

    // stage 7: divider seed, rem = 2*anum*|d| + aden, divisor 2*aden
    logic [2:0][RW-1:0] rem0_next;

    always_comb
    begin
        logic [RW-1:0] prod;
        for (int k = 0; k < 3; k++) begin
            prod = (RW'(ph_reg[k]) << H) + RW'(pl_reg[k]);
            rem0_next[k] = (prod << 1) + RW'(aden6_reg);
        end
    end

    // divider: one quotient bit per stage, msb first
    logic [2:0][RW-1:0] rem_reg  [D+1];
    logic [2:0][D-1:0]  q_reg    [D+1];
    logic [RW-1:0]      dd_reg   [D+1];
    logic               okd_reg  [D+1];
    logic [2:0][RW-1:0] rem_next [D];
    logic [2:0][D-1:0]  q_next   [D];

    always_comb
    begin
        logic [RW-1:0] dsh;
        for (int s = 0; s < D; s++) begin
            dsh = dd_reg[s] << (D - 1 - s);
            for (int k = 0; k < 3; k++) begin
                if (dsh <= rem_reg[s][k]) begin
                    rem_next[s][k] = rem_reg[s][k] - dsh;
                    q_next[s][k]   = q_reg[s][k] | (D'(1) << (D - 1 - s));
                end else begin
                    rem_next[s][k] = rem_reg[s][k];
                    q_next[s][k]   = q_reg[s][k];
                end
            end
        end
    end

    // stage P: rounded crossing point
    vec_t pt_next, pt_reg;
    vec_t tp0_reg, tp1_reg, tp2_reg;
    logic okp_reg;

    always_comb
    begin
        side_t sd;
        sd = side_reg[SD_DEPTH-1];
        for (int k = 0; k < 3; k++) begin
            if (sd.d[k][D-1])
                pt_next[k] = sd.a[k] - q_reg[D][k][C-1:0];
            else
                pt_next[k] = sd.a[k] + q_reg[D][k][C-1:0];
        end
    end

    // stage Q: edge vectors for the three same-side tests
    dvec_t u_next  [3], dp_next [3], dq_next [3];
    dvec_t u_reg   [3], dp_reg  [3], dq_reg  [3];
    vec_t  ptq_reg;
    logic  okq_reg;

    always_comb
    begin
        // edge t1-t2 against t0, edge t0-t2 against t1, edge t0-t1 against t2
        u_next[0]  = vdiff(tp2_reg, tp1_reg);
        dp_next[0] = vdiff(pt_reg,  tp1_reg);
        dq_next[0] = vdiff(tp0_reg, tp1_reg);
        u_next[1]  = vdiff(tp2_reg, tp0_reg);
        dp_next[1] = vdiff(pt_reg,  tp0_reg);
        dq_next[1] = vdiff(tp1_reg, tp0_reg);
        u_next[2]  = vdiff(tp1_reg, tp0_reg);
        dp_next[2] = vdiff(pt_reg,  tp0_reg);
        dq_next[2] = vdiff(tp2_reg, tp0_reg);
    end

    // stage R: cross products
    nvec_t c1_next [3], c2_next [3];
    nvec_t c1_reg  [3], c2_reg  [3];
    vec_t  ptr_reg;
    logic  okr_reg;

    always_comb
    begin
        for (int e = 0; e < 3; e++) begin
            c1_next[e] = vcross(u_reg[e], dp_reg[e]);
            c2_next[e] = vcross(u_reg[e], dq_reg[e]);
        end
    end

    // stage S: partial products of c1 . c2
    logic [PLW-1:0] dpl_next [3][3], dpl_reg [3][3];
    logic [PHW-1:0] dph_next [3][3], dph_reg [3][3];
    vec_t           pts_reg;
    logic           oks_reg;

    always_comb
    begin
        logic signed [PLW-1:0] plo;
        logic signed [PHW-1:0] phi;
        for (int e = 0; e < 3; e++) begin
            for (int k = 0; k < 3; k++) begin
                plo = $signed(c1_reg[e][k]) * $signed({1'b0, c2_reg[e][k][L-1:0]});
                phi = $signed(c1_reg[e][k]) * $signed(c2_reg[e][k][NW-1:L]);
                dpl_next[e][k] = plo;
                dph_next[e][k] = phi;
            end
        end
    end

    // stage T: edge signs and final decision
    logic hit_next, hit_reg;
    vec_t point_reg;

    always_comb
    begin
        logic signed [EW-1:0] acc;
        logic signed [EW-1:0] term;
        logic                 in_tri;
        in_tri = 1'b1;
        for (int e = 0; e < 3; e++) begin
            acc = '0;
            for (int k = 0; k < 3; k++) begin
                term = $signed(dph_reg[e][k]);
                acc  = acc + (term <<< L);
                term = $signed(dpl_reg[e][k]);
                acc  = acc + term;
            end
            if (acc[EW-1])
                in_tri = 1'b0;
        end
        hit_next = oks_reg && in_tri;
    end

    always_ff @(posedge clk)
    begin
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        w_reg       <= w_next;
        side_reg[0] <= side_next;
        for (int i = 1; i < SD_DEPTH; i++)
            side_reg[i] <= side_reg[i-1];

        n_reg  <= n_next;
        w2_reg <= w_reg;

        pden_reg <= pden_next;
        pnum_reg <= pnum_next;

        den_reg <= den_next;
        num_reg <= num_next;

        anum_reg <= anum_next;
        aden_reg <= aden_next;
        ok5_reg  <= ok5_next;

        pl_reg    <= pl_next;
        ph_reg    <= ph_next;
        aden6_reg <= aden_reg;
        ok6_reg   <= ok5_reg;

        rem_reg[0] <= rem0_next;
        q_reg[0]   <= '0;
        dd_reg[0]  <= RW'(aden6_reg) << 1;
        okd_reg[0] <= ok6_reg;
        for (int s = 0; s < D; s++) begin
            rem_reg[s+1] <= rem_next[s];
            q_reg[s+1]   <= q_next[s];
            dd_reg[s+1]  <= dd_reg[s];
            okd_reg[s+1] <= okd_reg[s];
        end

        pt_reg  <= pt_next;
        tp0_reg <= side_reg[SD_DEPTH-1].t0;
        tp1_reg <= side_reg[SD_DEPTH-1].t1;
        tp2_reg <= side_reg[SD_DEPTH-1].t2;
        okp_reg <= okd_reg[D];

        u_reg   <= u_next;
        dp_reg  <= dp_next;
        dq_reg  <= dq_next;
        ptq_reg <= pt_reg;
        okq_reg <= okp_reg;

        c1_reg  <= c1_next;
        c2_reg  <= c2_next;
        ptr_reg <= ptq_reg;
        okr_reg <= okq_reg;

        dpl_reg <= dpl_next;
        dph_reg <= dph_next;
        pts_reg <= ptr_reg;
        oks_reg <= okr_reg;

        hit_reg   <= hit_next;
        point_reg <= pts_reg;
    end

    assign hit   = hit_reg;
    assign point = point_reg;

endmodule

// ===== hdl/triangle_intersection_test.sv =====
// Channel   Handshake        Payload
// -------   --------------   ------------------------------------------------
// input     start / busy     mode, first_a, first_b, first_c,
//                            second_a, second_b, second_c
// result    done (strobe)    hit, crossing_point
//
// One transfer in per cycle; busy is tied low, every start is taken.
// Result strobes once the item has passed the engine pipeline and the output
// register; the depth is set by the restoring divider that produces
// the rounded crossing point, one quotient bit per stage.
// Reset clears only the valid pipe and done; data registers are not reset.
// The receiver cannot stall: done is high for exactly one cycle per item.
module triangle_intersection_test
    import tti_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [FIELD_W-1:0] first_a,
    input  logic [FIELD_W-1:0] first_b,
    input  logic [FIELD_W-1:0] first_c,
    input  logic [FIELD_W-1:0] second_a,
    input  logic [FIELD_W-1:0] second_b,
    input  logic [FIELD_W-1:0] second_c,
    output logic               done,
    output logic               hit,
    output logic [FIELD_W-1:0] crossing_point
);

    localparam int PTW     = 3 * COORD_BITS;
    localparam int SEG_LAT = seg_latency(COORD_BITS);

    // Packed points, bits above the three coordinates dropped
    logic [PTW-1:0] f_pt [3];
    logic [PTW-1:0] s_pt [3];

    assign f_pt[0] = first_a[PTW-1:0];
    assign f_pt[1] = first_b[PTW-1:0];
    assign f_pt[2] = first_c[PTW-1:0];
    assign s_pt[0] = second_a[PTW-1:0];
    assign s_pt[1] = second_b[PTW-1:0];
    assign s_pt[2] = second_c[PTW-1:0];

    // Six segment engines run on every item:
    //   0..2: edges of the second shape against the first triangle
    //         (engine 0 is also the segment test of mode 0)
    //   3..5: edges of the first triangle against the second triangle
    logic [SEG_TESTS-1:0] seg_hit;
    logic [PTW-1:0]       seg_point [SEG_TESTS];

    for (genvar i = 0; i < SEG_TESTS; i++) begin : g_seg
        localparam int J = i % 3;
        localparam int JN = (J + 1) % 3;
        if (i < 3) begin : g_fs
            tti_seg #(
                .COORD_BITS (COORD_BITS)
            ) u_seg (
                .clk   (clk),
                .tri_a (f_pt[0]),
                .tri_b (f_pt[1]),
                .tri_c (f_pt[2]),
                .seg_a (s_pt[J]),
                .seg_b (s_pt[JN]),
                .hit   (seg_hit[i]),
                .point (seg_point[i])
            );
        end else begin : g_sf
            tti_seg #(
                .COORD_BITS (COORD_BITS)
            ) u_seg (
                .clk   (clk),
                .tri_a (s_pt[0]),
                .tri_b (s_pt[1]),
                .tri_c (s_pt[2]),
                .seg_a (f_pt[J]),
                .seg_b (f_pt[JN]),
                .hit   (seg_hit[i]),
                .point (seg_point[i])
            );
        end
    end

    // Valid and mode travel alongside the engines
    logic [SEG_LAT-1:0] valid_reg, valid_next;
    logic [SEG_LAT-1:0] mode_reg,  mode_next;

    assign valid_next = {valid_reg[SEG_LAT-2:0], start};
    assign mode_next  = {mode_reg[SEG_LAT-2:0], mode};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
    end

    // Output stage: triangle mode ORs all six tests; the point is only
    // reported for a segment hit
    logic               done_reg, done_next;
    logic               hit_reg, hit_next;
    logic [FIELD_W-1:0] cp_reg, cp_next;

    always_comb
    begin
        done_next = valid_reg[SEG_LAT-1];
        if (mode_reg[SEG_LAT-1]) begin
            hit_next = |seg_hit;
            cp_next  = '0;
        end else begin
            hit_next = seg_hit[0];
            cp_next  = seg_hit[0] ? FIELD_W'(seg_point[0]) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        cp_reg  <= cp_next;
    end

    assign busy           = 1'b0;
    assign done           = done_reg;
    assign hit            = hit_reg;
    assign crossing_point = cp_reg;

`ifndef SYNTHESIS
    // every result strobe goes back to a transfer at the depth of the engines plus the output register
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, SEG_LAT + 1))
        else $error("result without matching transfer");

    // no point is reported on a miss
    a_miss_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (crossing_point == '0))
        else $error("crossing point set on a miss");

    // a point is only reported for a segment item
    a_point_mode0: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (crossing_point != '0)) |-> !$past(mode, SEG_LAT + 1))
        else $error("crossing point set in triangle mode");
`endif

endmodule
